FILE: rtl/core/apss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apss_pkg
// Shared widths, constants and status types of the audio prescaler select.
// ----------------------------------------------------------------------------
package apss_pkg;

    localparam int CFG_W          = 28;
    localparam int RATE_W         = 20;
    localparam int PRESC_W        = 5;
    localparam int WORD_W         = 16;
    localparam int PRESC_SHIFT    = 8;
    localparam int ENABLE_POS     = 15;
    localparam int PRESC_FIELD_MAX = 31;

    localparam logic [CFG_W-1:0] CLOCK_RATE_RESET = 28'd16934400;

    typedef struct packed {
        logic busy;
        logic done;
    } apss_div_stat_t;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } apss_seq_stat_t;

endpackage

FILE: rtl/core/apss_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apss_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module apss_div
    import apss_pkg::*;
#(
    parameter int DEN_W = 11
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [CFG_W-1:0]    dividend,
    input  logic [DEN_W-1:0]    divisor,
    output logic [CFG_W-1:0]    quotient,
    output apss_div_stat_t      stat
);

    localparam int CNT_W = $clog2(CFG_W);

    logic [CFG_W-1:0] dvd_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign shifted = {rem_reg, dvd_reg[CFG_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign ge      = shifted >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(CFG_W - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[CFG_W-2:0], ge};
            rem_reg <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        end
    end

    assign quotient  = dvd_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

FILE: rtl/core/apss_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apss_seq
// Sequencer: frame rate, divisor search, neighbor compare, result hold.
// ----------------------------------------------------------------------------
module apss_seq
    import apss_pkg::*;
#(
    parameter int CLOCKS_PER_FRAME = 384,
    parameter int DIVISOR_LIMIT    = 32,
    parameter int DEN_W            = 11
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [RATE_W-1:0]   want,
    input  logic [CFG_W-1:0]    clock_rate,
    input  logic                res_take,
    output apss_seq_stat_t      stat,
    output logic                div_start,
    output logic [CFG_W-1:0]    div_dividend,
    output logic [DEN_W-1:0]    div_divisor,
    input  logic [CFG_W-1:0]    div_quotient,
    input  apss_div_stat_t      div_stat,
    output logic                res_accepted,
    output logic [PRESC_W-1:0]  res_prescaler,
    output logic [WORD_W-1:0]   res_word,
    output logic [RATE_W-1:0]   res_rate
);

    localparam int FRAME_W = $clog2(((2 ** CFG_W) - 1) / CLOCKS_PER_FRAME + 1);
    localparam int CMP_W   = (FRAME_W > RATE_W) ? FRAME_W : RATE_W;
    localparam int DIV_W   = $clog2(DIVISOR_LIMIT + 2);
    localparam int LIMIT   = (DIVISOR_LIMIT - 1 > PRESC_FIELD_MAX) ?
                             PRESC_FIELD_MAX : DIVISOR_LIMIT - 1;
    localparam logic [DIV_W-1:0] LIMIT_D = DIV_W'(LIMIT);
    localparam logic [DIV_W-1:0] LAST_D  = DIV_W'(DIVISOR_LIMIT - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FRAME = 3'd1;
    localparam logic [2:0] S_SRCH  = 3'd2;
    localparam logic [2:0] S_UP    = 3'd3;
    localparam logic [2:0] S_PICK  = 3'd4;
    localparam logic [2:0] S_HOLD  = 3'd5;

    logic [2:0]         state_reg;
    logic               start_reg;
    logic [CFG_W-1:0]   op_dvd_reg;
    logic [DEN_W-1:0]   op_dsr_reg;
    logic [RATE_W-1:0]  want_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic [DIV_W-1:0]   div_reg;
    logic [FRAME_W-1:0] q_mid_reg;
    logic [FRAME_W-1:0] q_down_reg;
    logic [FRAME_W-1:0] q_up_reg;
    logic               acc_reg;
    logic [PRESC_W-1:0] presc_reg;

    logic [FRAME_W-1:0] q_new;
    logic [CMP_W-1:0]   want_x;
    logic [CMP_W-1:0]   e_mid;
    logic [CMP_W-1:0]   e_up;
    logic [CMP_W-1:0]   e_down;
    logic [DIV_W-1:0]   pick;
    logic [DIV_W-1:0]   presc_full;
    logic [DIV_W-1:0]   presc_sat;

    function automatic logic [CMP_W-1:0] abs_diff(input logic [CMP_W-1:0] a,
                                                  input logic [CMP_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    assign q_new  = div_quotient[FRAME_W-1:0];
    assign want_x = CMP_W'(want_reg);

    always_comb
    begin
        e_mid  = abs_diff(CMP_W'(q_mid_reg), want_x);
        e_up   = abs_diff(CMP_W'(q_up_reg), want_x);
        e_down = abs_diff(CMP_W'(q_down_reg), want_x);
        pick   = div_reg;
        if (e_up < e_mid)
        begin
            pick = div_reg + 1'b1;
        end
        if (e_down < e_mid)
        begin
            pick = div_reg - 1'b1;
        end
        presc_full = (pick == '0) ? '0 : pick - 1'b1;
        presc_sat  = (presc_full > LIMIT_D) ? LIMIT_D : presc_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            start_reg <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        start_reg <= 1'b1;
                        state_reg <= S_FRAME;
                    end
                end
                S_FRAME:
                begin
                    if (div_stat.done)
                    begin
                        if (want_x > CMP_W'(q_new >> 1))
                        begin
                            state_reg <= S_HOLD;
                        end
                        else
                        begin
                            start_reg <= 1'b1;
                            state_reg <= S_SRCH;
                        end
                    end
                end
                S_SRCH:
                begin
                    if (div_stat.done)
                    begin
                        start_reg <= 1'b1;
                        if (CMP_W'(q_new) < want_x || div_reg == LAST_D)
                        begin
                            state_reg <= S_UP;
                        end
                    end
                end
                S_UP:
                begin
                    if (div_stat.done)
                    begin
                        state_reg <= S_PICK;
                    end
                end
                S_PICK:
                begin
                    state_reg <= S_HOLD;
                end
                S_HOLD:
                begin
                    if (res_take)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                want_reg   <= want;
                op_dvd_reg <= clock_rate;
                op_dsr_reg <= DEN_W'(CLOCKS_PER_FRAME);
            end
            S_FRAME:
            begin
                if (div_stat.done)
                begin
                    frame_reg  <= q_new;
                    div_reg    <= DIV_W'(1);
                    op_dvd_reg <= CFG_W'(q_new);
                    op_dsr_reg <= DEN_W'(1);
                    acc_reg    <= 1'b0;
                    presc_reg  <= '0;
                end
            end
            S_SRCH:
            begin
                if (div_stat.done)
                begin
                    q_mid_reg  <= q_new;
                    op_dvd_reg <= CFG_W'(frame_reg);
                    op_dsr_reg <= DEN_W'(div_reg + 1'b1);
                    if (CMP_W'(q_new) < want_x)
                    begin
                        q_down_reg <= (div_reg == DIV_W'(1)) ? q_new : q_mid_reg;
                    end
                    else if (div_reg == LAST_D)
                    begin
                        // search ran out: the last quotient stands for the limit divisor
                        q_down_reg <= q_new;
                        div_reg    <= div_reg + 1'b1;
                        op_dsr_reg <= DEN_W'(div_reg + DIV_W'(2));
                    end
                    else
                    begin
                        div_reg <= div_reg + 1'b1;
                    end
                end
            end
            S_UP:
            begin
                if (div_stat.done)
                begin
                    q_up_reg <= q_new;
                end
            end
            S_PICK:
            begin
                acc_reg   <= 1'b1;
                presc_reg <= PRESC_W'(presc_sat);
            end
            default:
            begin
            end
        endcase
    end

    assign div_start     = start_reg;
    assign div_dividend  = op_dvd_reg;
    assign div_divisor   = op_dsr_reg;

    assign stat.idle      = (state_reg == S_IDLE);
    assign stat.res_valid = (state_reg == S_HOLD);

    assign res_accepted  = acc_reg;
    assign res_prescaler = acc_reg ? presc_reg : '0;
    assign res_word      = acc_reg ?
                           ((WORD_W'(presc_reg) << PRESC_SHIFT) | (WORD_W'(1) << ENABLE_POS))
                           : '0;
    assign res_rate      = acc_reg ? want_reg : '0;

endmodule

FILE: rtl/core/audio_prescaler_select_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_prescaler_select_core
// Picks the clock prescaler whose frame rate lies nearest a requested rate.
// ----------------------------------------------------------------------------
// Sequence: one serial division on the shared divider for the frame rate, one per
//   divisor tried (1 .. DIVISOR_LIMIT - 1) and one for the next divisor up, then a
//   pick step; a rejected rate ends after the frame-rate division.
// Throughput: one transaction at a time (the sequencer must be idle); the next can be
//   taken in the cycle after the result enters the output register (held by out_stall).
// Reset: clock_rate_reg returns to 16934400, sequencer idle, output empty.
// ----------------------------------------------------------------------------
module audio_prescaler_select_core
    import apss_pkg::*;
#(
    parameter int CLOCKS_PER_FRAME = 384,
    parameter int DIVISOR_LIMIT    = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [RATE_W-1:0]   requested_rate,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                accepted,
    output logic [PRESC_W-1:0]  prescaler,
    output logic [WORD_W-1:0]   register_word,
    output logic [RATE_W-1:0]   applied_rate
);

    localparam int DIV_W = $clog2(DIVISOR_LIMIT + 2);
    localparam int CPF_W = $clog2(CLOCKS_PER_FRAME + 1);
    localparam int DEN_W = (CPF_W > DIV_W) ? CPF_W : DIV_W;

    logic [CFG_W-1:0]   clock_rate_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               acc_reg;
    logic [PRESC_W-1:0] presc_reg;
    logic [WORD_W-1:0]  word_reg;
    logic [RATE_W-1:0]  rate_reg;

    apss_seq_stat_t     seq_stat;
    apss_div_stat_t     div_stat;
    logic               div_start;
    logic [CFG_W-1:0]   div_dividend;
    logic [DEN_W-1:0]   div_divisor;
    logic [CFG_W-1:0]   div_quotient;
    logic               res_accepted;
    logic [PRESC_W-1:0] res_prescaler;
    logic [WORD_W-1:0]  res_word;
    logic [RATE_W-1:0]  res_rate;
    logic               load;
    logic               in_go;

    assign cfg_ready = 1'b1;
    assign in_stall  = !seq_stat.idle;
    assign in_go     = in_valid && !in_stall;
    assign load      = seq_stat.res_valid && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_rate_reg <= CLOCK_RATE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            clock_rate_reg <= cfg_data;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            acc_reg   <= res_accepted;
            presc_reg <= res_prescaler;
            word_reg  <= res_word;
            rate_reg  <= res_rate;
        end
    end

    apss_div #(
        .DEN_W (DEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    apss_seq #(
        .CLOCKS_PER_FRAME (CLOCKS_PER_FRAME),
        .DIVISOR_LIMIT    (DIVISOR_LIMIT),
        .DEN_W            (DEN_W)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (in_go),
        .want          (requested_rate),
        .clock_rate    (clock_rate_reg),
        .res_take      (load),
        .stat          (seq_stat),
        .div_start     (div_start),
        .div_dividend  (div_dividend),
        .div_divisor   (div_divisor),
        .div_quotient  (div_quotient),
        .div_stat      (div_stat),
        .res_accepted  (res_accepted),
        .res_prescaler (res_prescaler),
        .res_word      (res_word),
        .res_rate      (res_rate)
    );

    assign out_valid     = out_valid_reg;
    assign accepted      = acc_reg;
    assign prescaler     = presc_reg;
    assign register_word = word_reg;
    assign applied_rate  = rate_reg;

endmodule

FILE: rtl/core/apss_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apss_chk
// Port-level checks of the prescaler select core, bound to the top level.
// ----------------------------------------------------------------------------
module apss_chk
    import apss_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic                accepted,
    input  logic [PRESC_W-1:0]  prescaler,
    input  logic [WORD_W-1:0]   register_word,
    input  logic [RATE_W-1:0]   applied_rate
);

    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(register_word)
            && $stable(prescaler) && $stable(accepted) && $stable(applied_rate))
        else $error("stalled result changed");

    // one transaction in flight: busy right after accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while busy");

    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !accepted |-> prescaler == '0 && register_word == '0
            && applied_rate == '0)
        else $error("rejected result not zero");

    a_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && accepted |-> register_word[ENABLE_POS]
            && register_word[PRESC_SHIFT+PRESC_W-1:PRESC_SHIFT] == prescaler
            && register_word[PRESC_SHIFT-1:0] == '0
            && register_word[ENABLE_POS-1:PRESC_SHIFT+PRESC_W] == '0)
        else $error("register word does not match prescaler");

endmodule

bind audio_prescaler_select_core apss_chk u_apss_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .accepted      (accepted),
    .prescaler     (prescaler),
    .register_word (register_word),
    .applied_rate  (applied_rate)
);

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for audio_prescaler_select_core. A scoreboard class
// predicts the prescaler choice for each accepted rate request and checks
// every result in order. Directed corner requests are followed by random
// phases over several master clock rates, with random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
    import apss_pkg::*;

    localparam int FRAME_CLOCKS   = 384;
    localparam int DIV_LIMIT      = 32;
    localparam int RATE_MAX       = (1 << RATE_W) - 1;
    localparam int CLOCK_MAX      = (1 << CFG_W) - 1;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 70;

    typedef struct packed {
        logic               accepted;
        logic [PRESC_W-1:0] prescaler;
        logic [WORD_W-1:0]  register_word;
        logic [RATE_W-1:0]  applied_rate;
    } prescale_result_t;

    class rate_scoreboard;
        logic [CFG_W-1:0] clock_rate;
        prescale_result_t expected_q[$];
        int errors;

        function new();
            clock_rate = CLOCK_RATE_RESET;
            errors = 0;
        endfunction

        function logic [CFG_W-1:0] distance(input logic [CFG_W-1:0] a, input logic [CFG_W-1:0] b);
            return (a > b) ? a - b : b - a;
        endfunction

        function prescale_result_t predict(input logic [RATE_W-1:0] want);
            prescale_result_t res;
            logic [CFG_W-1:0] frame;
            logic [CFG_W-1:0] q_mid;
            logic [CFG_W-1:0] q_up;
            logic [CFG_W-1:0] q_down;
            logic [CFG_W-1:0] e_mid;
            int div;
            int pick;
            int presc;
            int presc_max;
            res = '0;
            frame = CFG_W'(clock_rate / FRAME_CLOCKS);
            if (want > (frame >> 1))
                return res;
            q_mid = '0;
            for (div = 1; div < DIV_LIMIT; div++)
            begin
                q_mid = CFG_W'(frame / div);
                if (q_mid < want)
                    break;
            end
            q_up = CFG_W'(frame / (div + 1));
            q_down = (div > 1) ? CFG_W'(frame / (div - 1)) : q_mid;
            e_mid = distance(q_mid, want);
            pick = div;
            if (distance(q_up, want) < e_mid)
                pick = div + 1;
            if (distance(q_down, want) < e_mid)
                pick = div - 1;
            presc = (pick > 0) ? pick - 1 : 0;
            presc_max = (DIV_LIMIT - 1 < PRESC_FIELD_MAX) ? DIV_LIMIT - 1 : PRESC_FIELD_MAX;
            if (presc > presc_max)
                presc = presc_max;
            res.accepted = 1'b1;
            res.prescaler = presc[PRESC_W-1:0];
            res.register_word = WORD_W'((presc << PRESC_SHIFT) | (1 << ENABLE_POS));
            res.applied_rate = want;
            return res;
        endfunction

        function void note_rate(input logic [RATE_W-1:0] want);
            expected_q.push_back(predict(want));
        endfunction

        function void check_result(input prescale_result_t got);
            prescale_result_t exp_res;
            if (expected_q.size() == 0)
            begin
                $error("result transaction with no request pending");
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (got.accepted !== exp_res.accepted)
            begin
                $error("accepted: expected %0d, got %0d", exp_res.accepted, got.accepted);
                errors++;
            end
            if (got.prescaler !== exp_res.prescaler)
            begin
                $error("prescaler: expected %0d, got %0d", exp_res.prescaler, got.prescaler);
                errors++;
            end
            if (got.register_word !== exp_res.register_word)
            begin
                $error("register_word: expected 0x%04h, got 0x%04h",
                       exp_res.register_word, got.register_word);
                errors++;
            end
            if (got.applied_rate !== exp_res.applied_rate)
            begin
                $error("applied_rate: expected %0d, got %0d",
                       exp_res.applied_rate, got.applied_rate);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [RATE_W-1:0]  requested_rate;
    logic               out_valid;
    logic               out_stall;
    logic               accepted;
    logic [PRESC_W-1:0] prescaler;
    logic [WORD_W-1:0]  register_word;
    logic [RATE_W-1:0]  applied_rate;

    rate_scoreboard sb;
    logic quiet;
    int   idle_count;
    logic [CFG_W-1:0] phase_clock [PHASES];

    audio_prescaler_select_core #(
        .CLOCKS_PER_FRAME (FRAME_CLOCKS),
        .DIVISOR_LIMIT    (DIV_LIMIT)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .requested_rate (requested_rate),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .accepted       (accepted),
        .prescaler      (prescaler),
        .register_word  (register_word),
        .applied_rate   (applied_rate)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 9);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{accepted, prescaler, register_word, applied_rate});
    end

    // no-progress watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_count = 0;
        else
            idle_count++;
        if (idle_count >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_rate(input logic [RATE_W-1:0] want);
        int pause;
        pause = 0;
        if (!quiet && $urandom_range(0, 99) < 9)
            pause = $urandom_range(1, 1000);
        repeat (pause)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        requested_rate <= want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_rate(want);
    endtask

    task automatic release_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    // only called with nothing in flight
    task automatic write_clock_rate(input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.clock_rate = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [RATE_W-1:0] random_rate(input logic [CFG_W-1:0] clock_rate);
        longint frame;
        longint half;
        longint k;
        longint v;
        int mode;
        frame = clock_rate / FRAME_CLOCKS;
        half = frame >> 1;
        mode = $urandom_range(0, 99);
        if (mode < 45)
            v = $urandom_range(0, half);
        else if (mode < 65)
        begin
            k = $urandom_range(1, DIV_LIMIT + 1);
            v = frame / k + longint'($urandom_range(0, 4)) - 2;
        end
        else if (mode < 75)
        begin
            // midpoint between neighboring quotients: tie handling
            k = $urandom_range(1, DIV_LIMIT - 1);
            v = (frame / k + frame / (k + 1)) / 2 + longint'($urandom_range(0, 1));
        end
        else if (mode < 85)
            v = half + longint'($urandom_range(0, 2)) - 1;
        else
            v = $urandom_range(0, RATE_MAX);
        if (v < 0)
            v = 0;
        if (v > RATE_MAX)
            v = RATE_MAX;
        return v[RATE_W-1:0];
    endfunction

    initial
    begin
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        quiet = 1'b0;
        idle_count = 0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        requested_rate = '0;
        out_stall = 1'b0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset clock rate, frame rate 44100
        send_rate(20'd0);
        send_rate(20'd1);
        send_rate(20'd22050);
        send_rate(20'd22051);
        send_rate(20'hFFFFF);
        send_rate(20'd8000);
        send_rate(20'd14700);
        send_rate(20'd18375);
        send_rate(20'd1422);
        send_rate(20'd1423);
        send_rate(20'd1337);
        release_input();
        wait_drained();

        write_clock_rate('0);
        send_rate(20'd0);
        send_rate(20'd1);
        release_input();
        wait_drained();

        write_clock_rate(28'd767);
        send_rate(20'd0);
        send_rate(20'd1);
        release_input();
        wait_drained();

        write_clock_rate(CFG_W'(CLOCK_MAX));
        send_rate(20'd349525);
        send_rate(20'd349526);
        send_rate(20'h80000);
        release_input();
        wait_drained();

        phase_clock[0] = CFG_W'(CLOCK_MAX);
        phase_clock[1] = '0;
        phase_clock[2] = 28'd12288000;
        phase_clock[3] = 28'd11289600;
        phase_clock[4] = 28'd24576000;
        phase_clock[5] = CFG_W'($urandom_range(0, CLOCK_MAX));
        phase_clock[6] = CFG_W'($urandom_range(0, 100000));
        phase_clock[7] = CLOCK_RATE_RESET;

        for (int p = 0; p < PHASES; p++)
        begin
            write_clock_rate(phase_clock[p]);
            quiet = (p == 3);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_rate(random_rate(sb.clock_rate));
            release_input();
            wait_drained();
        end
        quiet = 1'b0;

        repeat (1000) @(posedge clk);
        if (sb.expected_q.size() != 0)
        begin
            $error("%0d results never arrived", sb.expected_q.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
